// ===== hdl/single_precision_float_adder_core_defines.svh =====
// Assertion macros for the float adder core.
`ifndef SINGLE_PRECISION_FLOAT_ADDER_CORE_DEFINES_SVH
`define SINGLE_PRECISION_FLOAT_ADDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SPFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPFA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPFA_ASSERT(label, prop, msg)
`define SPFA_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== hdl/spfa_pkg.sv =====
`timescale 1ns / 1ps
package spfa_pkg;
    localparam logic [22:0] FRAC_MASK = 23'h7FFFFF;
    localparam logic [7:0]  EXP_ALL   = 8'hFF;
    localparam logic [7:0]  EXP_MIN   = 8'd1;
    localparam logic [4:0]  SHIFT_CAP = 5'd31;
    localparam logic [26:0] OVF_MANT  = 27'h2000000;
    localparam logic [22:0] QUIET_BIT = 23'h400000;

    typedef struct packed {
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } spfa_in_t;

    typedef struct packed {
        logic [31:0] sum_value;
        logic        overflow_flag;
    } spfa_out_t;
endpackage

// ===== hdl/spfa_in_if.sv =====
`timescale 1ns / 1ps
interface spfa_in_if;
    import spfa_pkg::*;
    logic     valid;
    logic     ready;
    spfa_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/spfa_out_if.sv =====
`timescale 1ns / 1ps
interface spfa_out_if;
    import spfa_pkg::*;
    logic      valid;
    logic      ready;
    spfa_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/spfa_datapath.sv =====
`timescale 1ns / 1ps
module spfa_datapath (
    input  spfa_pkg::spfa_in_t  in_word,
    output spfa_pkg::spfa_out_t out_word
);
    import spfa_pkg::*;

    logic [31:0] a, b;
    logic [22:0] m1, m2;
    logic [7:0]  e1, e2, e1a, e2a, es, esi, eyd, eyr, ey;
    logic        s1, s2, ss, sel, tstck, stck, ovf1, ovf2, up, sy, same;
    logic [23:0] m1a, m2a, ms, mi;
    logic [7:0]  diff;
    logic [4:0]  de, se, sh;
    logic [54:0] mia;
    logic [26:0] al, mye, myd, myf;
    logic [24:0] myr;
    logic [22:0] my;
    logic signed [9:0] eyf;
    logic [31:0] y;

    always_comb
    begin
        a = in_word.operand_a;
        b = in_word.operand_b;
        m1 = a[22:0];
        m2 = b[22:0];
        e1 = a[30:23];
        e2 = b[30:23];
        s1 = a[31];
        s2 = b[31];
        same = (s1 == s2);
        m1a = {(e1 != 8'd0), m1};
        m2a = {(e2 != 8'd0), m2};
        e1a = (e1 != 8'd0) ? e1 : EXP_MIN;
        e2a = (e2 != 8'd0) ? e2 : EXP_MIN;
        if (e1a == e2a)
        begin
            diff = 8'd0;
            sel = !(m1a > m2a);
        end
        else if (e1a > e2a)
        begin
            diff = e1a - e2a;
            sel = 1'b0;
        end
        else
        begin
            diff = e2a - e1a;
            sel = 1'b1;
        end
        de = (diff > {3'd0, SHIFT_CAP}) ? SHIFT_CAP : diff[4:0];
        ms = sel ? m2a : m1a;
        mi = sel ? m1a : m2a;
        es = sel ? e2a : e1a;
        ss = sel ? s2 : s1;
        mia = {mi, 31'd0} >> de;
        tstck = (mia[28:0] != 29'd0);
        al = {1'b0, mia[54:29]};
        mye = same ? ({1'b0, ms, 2'b00} + al) : ({1'b0, ms, 2'b00} - al);

        esi = es + 8'd1;
        ovf1 = 1'b0;
        if (mye[26])
        begin
            if (esi == EXP_ALL)
            begin
                eyd = EXP_ALL;
                myd = OVF_MANT;
                stck = 1'b0;
                ovf1 = 1'b1;
            end
            else
            begin
                eyd = esi;
                myd = {1'b0, mye[26:1]};
                stck = tstck | mye[0];
            end
        end
        else
        begin
            eyd = es;
            myd = mye;
            stck = tstck;
        end

        se = 5'd26;
        for (int i = 1; i <= 25; i++)
        begin
            if (myd[i])
            begin
                se = 5'(25 - i);
            end
        end

        eyf = $signed({2'b00, eyd}) - $signed({5'd0, se});
        sh = (eyf > 0) ? se : 5'(eyd[4:0] - 5'd1);
        myf = myd << sh;
        eyr = (eyf > 0) ? eyf[7:0] : 8'd0;

        up = (myf[1] && !myf[0] && !stck && myf[2]) ||
             (myf[1] && !myf[0] && same && stck) ||
             (myf[1] && myf[0]);
        myr = myf[26:2] + {24'd0, up};

        ovf2 = 1'b0;
        if (myr[24])
        begin
            ey = eyr + 8'd1;
            my = 23'd0;
            ovf2 = (ey == EXP_ALL);
        end
        else if (myr[23:0] == 24'd0)
        begin
            ey = 8'd0;
            my = 23'd0;
        end
        else
        begin
            ey = (eyr == 8'd0 && myr[23]) ? EXP_MIN : eyr;
            my = myr[22:0] & FRAC_MASK;
        end
        sy = (ey == 8'd0 && my == 23'd0) ? (s1 & s2) : ss;

        if (e1 == EXP_ALL && e2 != EXP_ALL)
            y = {s1, EXP_ALL, ((m1 != 23'd0) ? QUIET_BIT : 23'd0) | {1'b0, m1[21:0]}};
        else if (e2 == EXP_ALL && e1 != EXP_ALL)
            y = {s2, EXP_ALL, ((m2 != 23'd0) ? QUIET_BIT : 23'd0) | {1'b0, m2[21:0]}};
        else if (e1 == EXP_ALL && m1 != 23'd0)
            y = {s1, EXP_ALL, QUIET_BIT | {1'b0, m1[21:0]}};
        else if (e1 == EXP_ALL && m2 != 23'd0)
            y = {s2, EXP_ALL, QUIET_BIT | {1'b0, m2[21:0]}};
        else if (e1 == EXP_ALL && same)
            y = {s1, EXP_ALL, 23'd0};
        else if (e1 == EXP_ALL)
            y = {1'b1, EXP_ALL, QUIET_BIT};
        else
            y = {sy, ey, my};

        out_word.sum_value = y;
        out_word.overflow_flag = (e1a != EXP_ALL) && (e2a != EXP_ALL) && (ovf1 || ovf2);
    end
endmodule

// ===== hdl/single_precision_float_adder_core.sv =====
`timescale 1ns / 1ps
// Binary32 adder: one operand pair word in, one sum word out, with an
// exponent overflow flag. Each word passes an input register, then a
// result register; a new word is accepted every cycle while the result
// side takes words. Rate is set by the single-pass add/normalize/round path.
`include "single_precision_float_adder_core_defines.svh"
module single_precision_float_adder_core (
    input logic  clk,
    input logic  rst_n,
    spfa_in_if.sink    operands,
    spfa_out_if.source result
);
    import spfa_pkg::*;

    logic      in_vld_reg, out_vld_reg;
    spfa_in_t  in_data_reg;
    spfa_out_t out_data_reg, calc;
    logic      out_adv, in_adv;

    assign out_adv = !out_vld_reg || result.ready;
    assign in_adv  = !in_vld_reg || out_adv;
    assign operands.ready = in_adv;
    assign result.valid = out_vld_reg;
    assign result.data  = out_data_reg;

    spfa_datapath u_dp (.in_word(in_data_reg), .out_word(calc));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
                in_vld_reg <= operands.valid;
            if (out_adv)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && operands.valid)
            in_data_reg <= operands.data;
        if (out_adv && in_vld_reg)
            out_data_reg <= calc;
    end

    `SPFA_ASSERT(a_hold, (result.valid && !result.ready) |=> result.valid, "result dropped")
    `SPFA_ASSERT(a_stall, (in_vld_reg && out_vld_reg && !result.ready) |-> !operands.ready, "overrun")
    `SPFA_ASSERT(a_move, (in_vld_reg && out_adv) |=> out_vld_reg, "word lost")
    `SPFA_ASSERT_RST(a_rst, !rst_n |-> !result.valid, "valid in reset")
endmodule
